// ===== sv/adc_average_piecewise_distance_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the averaging distance unit
// Concurrent checks on a rising clock with an active-low reset; they compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_PIECEWISE_DISTANCE_UNIT_DEFINES_SVH
`define ADC_AVERAGE_PIECEWISE_DISTANCE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define APD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define APD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define APD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define APD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/adc_apd_pkg.sv =====
// ----------------------------------------------------------------------------
// Averaging distance unit package
// Field widths, the piecewise-linear segment table and the mapping codes.
// ----------------------------------------------------------------------------
package adc_apd_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int DIST_W     = 12;
  localparam int MAP_W      = 12;
  localparam int OFF_W      = 8;
  localparam int RECIP_W    = 17;
  localparam int FRAC_SHIFT = 12;
  localparam int SEG_COUNT  = 7;
  localparam int SEG_W      = 3;

  typedef logic [MAP_W-1:0]         mean_t;
  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [RECIP_W-1:0]       recip_t;
  typedef logic [SEG_W-1:0]         seg_t;

  localparam mean_t FLOOR_MEAN = 12'd80;
  localparam mean_t TOP_MEAN   = 12'd490;
  localparam dist_t FLOOR_Q4   = 12'sd1280;
  localparam dist_t TOP_Q4     = 12'sd160;

  localparam mean_t SEG_LO [SEG_COUNT] = '{
    12'd80, 12'd87, 12'd106, 12'd124, 12'd150, 12'd196, 12'd276
  };

  localparam dist_t SEG_BASE_Q4 [SEG_COUNT] = '{
    12'sd1280, 12'sd1120, 12'sd960, 12'sd800, 12'sd640, 12'sd480, 12'sd320
  };

  localparam recip_t SEG_RECIP [SEG_COUNT] = '{
    17'd85112, 17'd31060, 17'd32768, 17'd22756, 17'd12825, 17'd7380, 17'd7380
  };

  typedef enum logic [1:0] {
    KIND_FLOOR = 2'd0,
    KIND_TOP   = 2'd1,
    KIND_HELD  = 2'd2,
    KIND_SEG   = 2'd3
  } map_kind_t;

endpackage

// ===== sv/adc_average_piecewise_distance_unit.sv =====
// ----------------------------------------------------------------------------
// Averaging piecewise-linear IR distance unit
// Sums blocks of ADC samples, takes the mean and maps it to centimetres.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel, one beat per sample, and the unit can
// take a sample in every cycle unless a closing sample meets full stages.
// Each block of SAMPLE_COUNT samples produces one beat on the out_ channel:
// the distance in signed Q4 centimetres and a held flag that marks a mean
// above 490, for which the previous distance is repeated.
// The result of a block is registered in turn: the block total at the edge
// that accepts its last sample, the mean after the reciprocal multiply,
// the segment after the lookup and the output register after the slope
// multiply.
// One sample per cycle while in_ready holds, one result per SAMPLE_COUNT samples.
// While the receiver stalls, samples that do not close a block are still
// taken; a closing sample is taken as long as the four stages have a free
// slot, so in_ready drops only when all of them hold results.
// Synchronous reset clears the running sum, the sample count, the stage
// valid flags and the stored last distance, which reads as zero until a
// block maps to a mean of 490 or below.
// ----------------------------------------------------------------------------
`include "adc_average_piecewise_distance_unit_defines.svh"

module adc_average_piecewise_distance_unit
  import adc_apd_pkg::*;
#(
  parameter int SAMPLE_COUNT = 20,
  parameter int ADC_BITS     = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DIST_W-1:0] out_distance_q4,
  output logic                     out_held
);

  localparam int SUM_W  = $clog2(SAMPLE_COUNT * ((1 << ADC_BITS) - 1) + 1);
  localparam int IDX_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int DIV_L  = $clog2(SAMPLE_COUNT);
  localparam int SHIFT  = SUM_W + DIV_L;
  localparam int M_W    = SUM_W + 2;
  localparam int PROD_W = SUM_W + M_W;
  localparam logic [M_W-1:0] DIV_RECIP =
    M_W'(((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

  logic [ADC_BITS-1:0] s;
  logic [SUM_W-1:0]    total;
  logic                closing;
  logic                in_fire;

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic                a_v_r, b_v_r, c_v_r, out_v_r;
  logic                a_rdy, b_rdy, c_rdy, o_rdy;

  logic [SUM_W-1:0]    total_r;
  logic [PROD_W-1:0]   div_prod;
  logic [ADC_BITS-1:0] mean_r, mean_nxt;

  mean_t               m;
  seg_t                seg_nxt, seg_r;
  logic [OFF_W-1:0]    off_nxt, off_r;
  map_kind_t           kind_nxt, kind_r;

  logic [OFF_W+RECIP_W-1:0] slope_prod;
  dist_t               drop;
  dist_t               dist_nxt;
  dist_t               dist_r;
  logic                held_r;
  dist_t               last_r;

  assign s       = ADC_BITS'(in_sample);
  assign total   = sum_r + SUM_W'(s);
  assign closing = (idx_r == LAST_IDX);

  assign o_rdy    = !out_v_r || out_ready;
  assign c_rdy    = !c_v_r || o_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = !closing || a_rdy;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    if (in_fire) begin
      if (closing) begin
        sum_nxt = '0;
        idx_nxt = '0;
      end else begin
        sum_nxt = total;
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  assign div_prod = PROD_W'(total_r) * PROD_W'(DIV_RECIP);
  assign mean_nxt = ADC_BITS'(div_prod >> SHIFT);

  assign m = MAP_W'(mean_r);

  always_comb begin
    seg_nxt = '0;
    for (int k = 1; k < SEG_COUNT; k++) begin
      if (m >= SEG_LO[k]) begin
        seg_nxt = SEG_W'(k);
      end
    end
    off_nxt = OFF_W'(m - SEG_LO[seg_nxt]);
    if (m <= FLOOR_MEAN) begin
      kind_nxt = KIND_FLOOR;
    end else if (m == TOP_MEAN) begin
      kind_nxt = KIND_TOP;
    end else if (m > TOP_MEAN) begin
      kind_nxt = KIND_HELD;
    end else begin
      kind_nxt = KIND_SEG;
    end
  end

  assign slope_prod = (OFF_W+RECIP_W)'(off_r) * (OFF_W+RECIP_W)'(SEG_RECIP[seg_r]);
  assign drop       = DIST_W'(slope_prod >> FRAC_SHIFT);

  always_comb begin
    case (kind_r)
      KIND_FLOOR: dist_nxt = FLOOR_Q4;
      KIND_TOP:   dist_nxt = TOP_Q4;
      KIND_HELD:  dist_nxt = last_r;
      KIND_SEG:   dist_nxt = SEG_BASE_Q4[seg_r] - drop;
      default:    dist_nxt = FLOOR_Q4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      idx_r   <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      last_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
      if (a_rdy) begin
        a_v_r <= in_fire && closing;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (c_rdy) begin
        c_v_r <= b_v_r;
      end
      if (o_rdy) begin
        out_v_r <= c_v_r;
      end
      if (o_rdy && c_v_r && (kind_r != KIND_HELD)) begin
        last_r <= dist_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_fire && closing) begin
      total_r <= total;
    end
    if (b_rdy && a_v_r) begin
      mean_r <= mean_nxt;
    end
    if (c_rdy && b_v_r) begin
      seg_r  <= seg_nxt;
      off_r  <= off_nxt;
      kind_r <= kind_nxt;
    end
    if (o_rdy && c_v_r) begin
      dist_r <= dist_nxt;
      held_r <= (kind_r == KIND_HELD);
    end
  end

  assign out_valid       = out_v_r;
  assign out_distance_q4 = dist_r;
  assign out_held        = held_r;

  `APD_ASSERT_IMPLY(a_idx_range, clk, rst_n, 1'b1, idx_r <= LAST_IDX,
    "sample count ran past the block length")
  `APD_ASSERT_NEXT(a_close_loads, clk, rst_n, in_fire && closing, a_v_r,
    "closing sample did not load the total stage")
  `APD_ASSERT_IMPLY(a_out_is_last, clk, rst_n, out_v_r, dist_r == last_r,
    "pending result differs from the stored last distance")
  `APD_ASSERT_IMPLY(a_dist_range, clk, rst_n, out_v_r && !held_r,
    (dist_r <= FLOOR_Q4) && (dist_r >= -12'sd64),
    "mapped distance out of range")

endmodule
